// ----- rtl/ira_pkg.sv -----
// Shared types and constants for the IQ rotate / average / autogain block.
// No dependencies; used by every module under rtl/.
package ira_pkg;

  // Channel lanes carried by one sweep point
  localparam int NumLanes = 4;

  // Sample and rotation widths
  localparam int SmpW  = 16;
  localparam int RotW  = 32;
  localparam int ProdW = SmpW + RotW;
  localparam int FracW = 31;
  localparam int PowW  = 32;
  localparam int SumW  = SmpW + 3;

  // Rounding bias for the 2^31 scale-down: 2^30
  localparam logic [ProdW-1:0] RotRound = ProdW'(64'h4000_0000);

  // Channel id of the four-channel mean word
  localparam logic [2:0] MeanId = 3'd4;

  // Autogain thresholds and gain range
  localparam logic [SmpW-1:0] GainUpThreshold    = 16'd6100;
  localparam logic [SmpW-1:0] MinGainUpThreshold = GainUpThreshold >> 6;
  localparam logic [2:0]      MaxGain            = 3'd7;
  localparam logic [2:0]      MinGain            = 3'd0;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgAutogainOn  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCurrentGain = 2'd1;

  typedef logic signed [SmpW-1:0] smp_t;
  typedef logic signed [RotW-1:0] rot_t;
  typedef logic        [SmpW-1:0] mag_t;
  typedef logic        [PowW-1:0] pow_t;

  // Per-stage load enables of the point pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } en_t;

  // End-of-sweep flags that ride with the mean word
  typedef struct packed {
    logic       last;
    logic       gain_write;
    logic [2:0] new_gain;
  } side_t;

endpackage

// ----- rtl/ira_rotate.sv -----
// One channel lane: 16x32 rotation products, rounding to 16 bits, one delay stage.
// Depends on ira_pkg.
module ira_rotate (
  input  logic          clk_i,
  input  ira_pkg::en_t  en_i,
  input  ira_pkg::smp_t x_i,
  input  ira_pkg::smp_t y_i,
  input  ira_pkg::rot_t c_i,
  input  ira_pkg::rot_t s_i,
  output ira_pkg::mag_t mag_o,
  output ira_pkg::smp_t i2_o,
  output ira_pkg::smp_t q2_o,
  output ira_pkg::smp_t i3_o,
  output ira_pkg::smp_t q3_o
);

  logic signed [ira_pkg::ProdW-1:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [ira_pkg::ProdW-1:0] xc_d, ys_d, xs_d, yc_d;
  ira_pkg::mag_t mx, my, mag_q;
  logic [ira_pkg::ProdW-1:0] sum_i, sum_q;
  ira_pkg::smp_t i2_q, q2_q, i3_q, q3_q;

  // Stage 1: products and raw magnitude
  assign xc_d = x_i * c_i;
  assign ys_d = y_i * s_i;
  assign xs_d = x_i * s_i;
  assign yc_d = y_i * c_i;
  assign mx   = x_i[ira_pkg::SmpW-1] ? ira_pkg::mag_t'(-x_i) : ira_pkg::mag_t'(x_i);
  assign my   = y_i[ira_pkg::SmpW-1] ? ira_pkg::mag_t'(-y_i) : ira_pkg::mag_t'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      xc_q  <= xc_d;
      ys_q  <= ys_d;
      xs_q  <= xs_d;
      yc_q  <= yc_d;
      mag_q <= (mx > my) ? mx : my;
    end
  end

  // Stage 2: round by 2^31, keep 16 bits (wrap)
  assign sum_i = xc_q - ys_q + ira_pkg::RotRound;
  assign sum_q = xs_q + yc_q + ira_pkg::RotRound;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      i2_q <= sum_i[ira_pkg::FracW+ira_pkg::SmpW-1:ira_pkg::FracW];
      q2_q <= sum_q[ira_pkg::FracW+ira_pkg::SmpW-1:ira_pkg::FracW];
    end
  end

  // Stage 3: wait while the mean is formed
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      i3_q <= i2_q;
      q3_q <= q2_q;
    end
  end

  assign mag_o = mag_q;
  assign i2_o  = i2_q;
  assign q2_o  = q2_q;
  assign i3_o  = i3_q;
  assign q3_o  = q3_q;

endmodule

// ----- rtl/ira_power.sv -----
// Power unit: squares I and Q, then sums them, over two registered stages.
// Depends on ira_pkg.
module ira_power (
  input  logic          clk_i,
  input  ira_pkg::en_t  en_i,
  input  ira_pkg::smp_t i_i,
  input  ira_pkg::smp_t q_i,
  output ira_pkg::smp_t i_o,
  output ira_pkg::smp_t q_o,
  output ira_pkg::pow_t power_o
);

  logic signed [2*ira_pkg::SmpW-1:0] pi, pq;
  logic [2*ira_pkg::SmpW-2:0] sqi_q, sqq_q;
  ira_pkg::smp_t i4_q, q4_q, i5_q, q5_q;
  ira_pkg::pow_t pow_q;

  assign pi = i_i * i_i;
  assign pq = q_i * q_i;

  // Stage 4: squares (never negative, top bit dropped)
  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      sqi_q <= pi[2*ira_pkg::SmpW-2:0];
      sqq_q <= pq[2*ira_pkg::SmpW-2:0];
      i4_q  <= i_i;
      q4_q  <= q_i;
    end
  end

  // Stage 5: sum of squares
  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      pow_q <= {1'b0, sqi_q} + {1'b0, sqq_q};
      i5_q  <= i4_q;
      q5_q  <= q4_q;
    end
  end

  assign i_o     = i5_q;
  assign q_o     = q5_q;
  assign power_o = pow_q;

endmodule

// ----- rtl/ira_merge.sv -----
// Merge stage: sweep peak tracking, autogain proposal and four-channel mean.
// Depends on ira_pkg; fed by the ira_rotate lanes.
module ira_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ira_pkg::en_t          en_i,
  input  logic                  peak_upd_i,
  input  logic                  last_i,
  input  logic                  ovf_i,
  input  ira_pkg::mag_t         mag_i [ira_pkg::NumLanes],
  input  ira_pkg::smp_t         i2_i  [ira_pkg::NumLanes],
  input  ira_pkg::smp_t         q2_i  [ira_pkg::NumLanes],
  input  logic                  agc_on_i,
  input  logic [2:0]            gain_i,
  output ira_pkg::smp_t         mean_i_o,
  output ira_pkg::smp_t         mean_q_o,
  output ira_pkg::side_t        side_o
);

  logic last1_q, ovf1_q, last2_q, ovf2_q;
  ira_pkg::mag_t peak_q, peak_d, pk2_q, m01, m23, m03;
  logic signed [ira_pkg::SumW-1:0] isum, qsum;
  logic signed [ira_pkg::SumW-3:0] mi, mq;
  ira_pkg::smp_t mi_q, mq_q;
  ira_pkg::side_t side_d, side3_q, side4_q, side5_q;

  // Stage 1: sweep flags
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      last1_q <= last_i;
      ovf1_q  <= ovf_i;
    end
  end

  // Peak over lanes and the running sweep peak
  assign m01    = (mag_i[0] > mag_i[1]) ? mag_i[0] : mag_i[1];
  assign m23    = (mag_i[2] > mag_i[3]) ? mag_i[2] : mag_i[3];
  assign m03    = (m01 > m23) ? m01 : m23;
  assign peak_d = (m03 > peak_q) ? m03 : peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (peak_upd_i) begin
      peak_q <= last1_q ? '0 : peak_d;
    end
  end

  // Stage 2: peak seen up to and including this point
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pk2_q   <= peak_d;
      last2_q <= last1_q;
      ovf2_q  <= ovf1_q;
    end
  end

  // Gain proposal at sweep end
  always_comb begin
    side_d            = '0;
    side_d.last       = last2_q;
    if (last2_q && agc_on_i) begin
      if (ovf2_q) begin
        if (gain_i != ira_pkg::MaxGain) begin
          side_d.gain_write = 1'b1;
          side_d.new_gain   = gain_i + 3'd1;
        end
      end else if (gain_i != ira_pkg::MaxGain && pk2_q < ira_pkg::GainUpThreshold) begin
        if (gain_i != ira_pkg::MinGain) begin
          side_d.gain_write = 1'b1;
          side_d.new_gain   = gain_i - 3'd1;
        end
      end else if (gain_i == ira_pkg::MaxGain && pk2_q < ira_pkg::MinGainUpThreshold) begin
        side_d.gain_write = 1'b1;
        side_d.new_gain   = gain_i - 3'd1;
      end
    end
  end

  // Mean: (sum + 2) / 4, truncated toward zero
  always_comb begin
    isum = ira_pkg::SumW'(2);
    qsum = ira_pkg::SumW'(2);
    for (int k = 0; k < ira_pkg::NumLanes; k++) begin
      isum = isum + ira_pkg::SumW'(i2_i[k]);
      qsum = qsum + ira_pkg::SumW'(q2_i[k]);
    end
    mi = isum[ira_pkg::SumW-1:2] + ((isum[ira_pkg::SumW-1] && isum[1:0] != 2'b00) ? 1 : 0);
    mq = qsum[ira_pkg::SumW-1:2] + ((qsum[ira_pkg::SumW-1] && qsum[1:0] != 2'b00) ? 1 : 0);
  end

  // Stage 3: mean and proposal
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      mi_q    <= mi[ira_pkg::SmpW-1:0];
      mq_q    <= mq[ira_pkg::SmpW-1:0];
      side3_q <= side_d;
    end
  end

  // Stages 4 and 5: flags follow the power units
  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      side4_q <= side3_q;
    end
    if (en_i.s5) begin
      side5_q <= side4_q;
    end
  end

  assign mean_i_o = mi_q;
  assign mean_q_o = mq_q;
  assign side_o   = side5_q;

endmodule

// ----- rtl/iq_rotate_average_autogain.sv -----
// Top level: IQ rotation, four-channel mean and autogain proposal.
// Depends on ira_pkg, ira_rotate, ira_merge and ira_power.
//
// One sweep point enters as one input word and leaves as five output words:
// channels 0 to 3, then the mean (tlast high). Four lanes rotate the channels
// in parallel, a merge stage forms the mean, tracks the sweep peak and makes
// the gain proposal on the mean word of the last point. An input word passes
// the registered pipeline stages and then the output buffer before its first
// output word leaves. The output channel delivers five words per point, which
// sets the sustained rate; the input side accepts the next point while the current one drains.
// Config writes are taken every cycle and belong in idle periods.
module iq_rotate_average_autogain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input word. tdata from bit 0 up: raw_i_ch0..3, raw_q_ch0..3 (16b each),
  // rot_cos, rot_sin (32b each)
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [191:0]                  s_axis_tdata,
  input  logic                          s_axis_tlast,   // last_point
  input  logic                          s_axis_tuser,   // scale_overflow
  // Output word. tdata from bit 0 up: i_out (16b), q_out (16b), power (32b),
  // new_gain (3b), zero pad (5b)
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,   // run_last
  // tuser from bit 0 up: channel_id (3b), sweep_end, gain_write
  output logic [4:0]                    m_axis_tuser,
  // Config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ira_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ira_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int N = ira_pkg::NumLanes;

  logic agc_on_q;
  logic [2:0] gain_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  ira_pkg::en_t en;

  ira_pkg::smp_t x_in [N];
  ira_pkg::smp_t y_in [N];
  ira_pkg::rot_t c_in, s_in;
  ira_pkg::mag_t mag   [N];
  ira_pkg::smp_t i2    [N];
  ira_pkg::smp_t q2    [N];
  ira_pkg::smp_t i3    [N+1];
  ira_pkg::smp_t q3    [N+1];
  ira_pkg::smp_t i5    [N+1];
  ira_pkg::smp_t q5    [N+1];
  ira_pkg::pow_t pw5   [N+1];
  ira_pkg::side_t side5;

  logic buf_v_q;
  logic [2:0] idx_q;
  ira_pkg::smp_t res_i_q [N+1];
  ira_pkg::smp_t res_q_q [N+1];
  ira_pkg::pow_t res_p_q [N+1];
  ira_pkg::side_t side_q;
  logic is_mean, take, load;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agc_on_q <= 1'b0;
      gain_q   <= 3'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ira_pkg::CfgAutogainOn:  agc_on_q <= cfg_data_i[0];
        ira_pkg::CfgCurrentGain: gain_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or emptying
  assign is_mean = (idx_q == ira_pkg::MeanId);
  assign take    = buf_v_q && m_axis_tready;
  assign rdy6    = !buf_v_q || (take && is_mean);
  assign rdy5    = !v5_q || rdy6;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign load    = v5_q && rdy6;

  assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Unpack input word
  always_comb begin
    for (int k = 0; k < N; k++) begin
      x_in[k] = s_axis_tdata[k*ira_pkg::SmpW +: ira_pkg::SmpW];
      y_in[k] = s_axis_tdata[(N+k)*ira_pkg::SmpW +: ira_pkg::SmpW];
    end
  end
  assign c_in = s_axis_tdata[2*N*ira_pkg::SmpW +: ira_pkg::RotW];
  assign s_in = s_axis_tdata[2*N*ira_pkg::SmpW+ira_pkg::RotW +: ira_pkg::RotW];

  // Channel lanes
  for (genvar g = 0; g < N; g++) begin : g_lane
    ira_rotate u_rot (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (x_in[g]),
      .y_i   (y_in[g]),
      .c_i   (c_in),
      .s_i   (s_in),
      .mag_o (mag[g]),
      .i2_o  (i2[g]),
      .q2_o  (q2[g]),
      .i3_o  (i3[g]),
      .q3_o  (q3[g])
    );
  end

  // Merge: peak, gain proposal, mean
  ira_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .peak_upd_i (v1_q && rdy2),
    .last_i     (s_axis_tlast),
    .ovf_i      (s_axis_tuser),
    .mag_i      (mag),
    .i2_i       (i2),
    .q2_i       (q2),
    .agc_on_i   (agc_on_q),
    .gain_i     (gain_q),
    .mean_i_o   (i3[N]),
    .mean_q_o   (q3[N]),
    .side_o     (side5)
  );

  // Power units: four channels plus the mean
  for (genvar g = 0; g <= N; g++) begin : g_pow
    ira_power u_pow (
      .clk_i   (clk_i),
      .en_i    (en),
      .i_i     (i3[g]),
      .q_i     (q3[g]),
      .i_o     (i5[g]),
      .q_o     (q5[g]),
      .power_o (pw5[g])
    );
  end

  // Output buffer: five words of one point, sent in channel order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_v_q <= 1'b0;
      idx_q   <= 3'd0;
    end else if (load) begin
      buf_v_q <= 1'b1;
      idx_q   <= 3'd0;
    end else if (take) begin
      if (is_mean) begin
        buf_v_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k <= N; k++) begin
        res_i_q[k] <= i5[k];
        res_q_q[k] <= q5[k];
        res_p_q[k] <= pw5[k];
      end
      side_q <= side5;
    end
  end

  // Output word
  assign m_axis_tvalid = buf_v_q;
  assign m_axis_tlast  = is_mean;
  assign m_axis_tuser  = {is_mean & side_q.gain_write, is_mean & side_q.last, idx_q};
  assign m_axis_tdata  = {5'b0, is_mean ? side_q.new_gain : 3'd0,
                          res_p_q[idx_q], res_q_q[idx_q], res_i_q[idx_q]};

`ifndef ASSERT_OFF
  // Gain proposal only on the mean word of a sweep's last point
  a_gain_on_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[4]) |-> (is_mean && side_q.last))
    else $error("gain proposal outside sweep-end mean word");

  // Word counter never passes the mean word
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_v_q |-> (idx_q <= ira_pkg::MeanId))
    else $error("output word counter out of range");

  // With the output buffer empty the whole pipeline accepts
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !buf_v_q |-> s_axis_tready)
    else $error("input stalled with empty output buffer");

  // A buffer load always starts at channel 0 on the next cycle
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (buf_v_q && idx_q == 3'd0))
    else $error("output buffer load did not restart at channel 0");
`endif

endmodule

// ----- tb/iq_rotate_average_autogain_tb.sv -----
// Testbench for iq_rotate_average_autogain: sweeps of points with random stalls,
// every output word checked against an in-bench rotation/mean/autogain predictor.
// Depends on ira_pkg and the iq_rotate_average_autogain RTL.
`timescale 1ns / 100ps

module iq_rotate_average_autogain_tb;
  import ira_pkg::*;

  localparam int CycleLimit = 600_000;
  localparam int ReportMax  = 40;

  // Rotation constants, scaled by 2^31
  localparam logic [31:0] RotOne      = 32'h4000_0000;
  localparam logic [31:0] RotMinusOne = 32'hC000_0000;
  localparam logic [31:0] RotUnity    = 32'h7FFF_FFFF;  // identity within rounding
  localparam logic [31:0] RotMin      = 32'h8000_0000;

  // Register indexes the block ignores
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // Sample classes of a random sweep
  typedef enum int {LvlTiny, LvlNearThreshold, LvlFull} level_e;

  typedef struct packed {
    logic [31:0]      sin_v;
    logic [31:0]      cos_v;
    logic [3:0][15:0] raw_q;
    logic [3:0][15:0] raw_i;
    logic             last;
    logic             ovf;
  } point_t;

  typedef struct packed {
    logic [2:0]  chan;
    logic [15:0] i_val;
    logic [15:0] q_val;
    logic [31:0] pwr;
    logic        run_last;
    logic        sweep_end;
    logic [2:0]  gain;
    logic        gain_wr;
  } word_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [191:0]         s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [71:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic [4:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // Predictor state
  logic        autogain_en = 1'b0;
  logic [2:0]  gain_in_use = 3'd0;
  logic [15:0] peak_mag = 16'd0;
  word_t       pending_words[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit traffic_idle = 1'b1;
  int stall_left = 0;

  iq_rotate_average_autogain dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: random stall bursts while idling is on
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (traffic_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // floor((a*c + b*d + 2^30) / 2^31), low 16 bits
  function automatic logic [15:0] rot_dot(input longint a, input longint b,
                                          input longint c, input longint d);
    longint acc;
    acc = a * c + b * d + 64'sd1073741824;
    acc = acc >>> 31;
    return acc[15:0];
  endfunction

  function automatic word_t make_word(input logic [2:0] chan, input logic [15:0] iv,
                                      input logic [15:0] qv);
    word_t  w;
    longint a, b;
    a = $signed(iv);
    b = $signed(qv);
    w = '0;
    w.chan = chan;
    w.i_val = iv;
    w.q_val = qv;
    w.pwr = a * a + b * b;
    return w;
  endfunction

  // Expected five words of one point; updates the sweep peak
  function automatic void rotate_and_average(input point_t p);
    longint      cs, sn, x, y, mag, isum, qsum, mean_i, mean_q;
    logic [15:0] ri, rq;
    word_t       w;
    int          ch, g, ng;
    cs = $signed(p.cos_v);
    sn = $signed(p.sin_v);
    isum = 0;
    qsum = 0;
    for (ch = 0; ch < NumLanes; ch++) begin
      x = $signed(p.raw_i[ch]);
      y = $signed(p.raw_q[ch]);
      mag = (x < 0) ? -x : x;
      if (mag > peak_mag) peak_mag = mag[15:0];
      mag = (y < 0) ? -y : y;
      if (mag > peak_mag) peak_mag = mag[15:0];
      ri = rot_dot(x, y, cs, -sn);
      rq = rot_dot(x, y, sn, cs);
      isum += $signed(ri);
      qsum += $signed(rq);
      pending_words.push_back(make_word(3'(ch), ri, rq));
    end
    // mean rounds half up, then truncates toward zero
    mean_i = (isum + 2) / 4;
    mean_q = (qsum + 2) / 4;
    w = make_word(MeanId, mean_i[15:0], mean_q[15:0]);
    w.run_last = 1'b1;
    if (p.last) begin
      w.sweep_end = 1'b1;
      if (autogain_en) begin
        g = int'(gain_in_use);
        ng = g;
        if (p.ovf)
          ng = g + 1;
        else if (g < int'(MaxGain) && peak_mag < GainUpThreshold)
          ng = g - 1;
        else if (g == int'(MaxGain) && peak_mag < MinGainUpThreshold)
          ng = g - 1;
        if (ng >= int'(MinGain) && ng <= int'(MaxGain) && ng != g) begin
          w.gain = 3'(ng);
          w.gain_wr = 1'b1;
        end
      end
      peak_mag = 16'd0;
    end
    pending_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= ReportMax)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : word_check
    word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("%0t: unexpected word, expected none, actual tdata %h tuser %h",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_words.pop_front();
        compare_field("channel_id", want.chan, m_axis_tuser[2:0]);
        compare_field("i_out", $signed(want.i_val), $signed(m_axis_tdata[15:0]));
        compare_field("q_out", $signed(want.q_val), $signed(m_axis_tdata[31:16]));
        compare_field("power", want.pwr, m_axis_tdata[63:32]);
        compare_field("run_last", want.run_last, m_axis_tlast);
        compare_field("sweep_end", want.sweep_end, m_axis_tuser[3]);
        compare_field("new_gain", want.gain, m_axis_tdata[66:64]);
        compare_field("gain_write", want.gain_wr, m_axis_tuser[4]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // tvalid stays high into the next call; only an idle gap or a drain lowers it
  task automatic send_point(input point_t p);
    int gap;
    if (traffic_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.sin_v, p.cos_v, p.raw_q, p.raw_i};
    s_axis_tlast  <= p.last;
    s_axis_tuser  <= p.ovf;
    do @(posedge clk_i); while (!s_axis_tready);
    rotate_and_average(p);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgAutogainOn)
      autogain_en = val[0];
    else if (idx == CfgCurrentGain)
      gain_in_use = val[2:0];
  endtask

  // Only written with the pipeline empty
  task automatic program_regs(input logic [7:0] on_val, input logic [7:0] gain_val,
                              input bit with_spare);
    wait_drained();
    if (with_spare)
      write_reg($urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo, 8'($urandom()));
    write_reg(CfgAutogainOn, on_val);
    write_reg(CfgCurrentGain, gain_val);
    cfg_valid_i <= 1'b0;
  endtask

  // Channel vectors are given ch3 first
  function automatic point_t mk_point(input logic [3:0][15:0] iv, input logic [3:0][15:0] qv,
                                      input logic [31:0] c, input logic [31:0] s,
                                      input bit last, input bit ovf);
    point_t p;
    p.raw_i = iv;
    p.raw_q = qv;
    p.cos_v = c;
    p.sin_v = s;
    p.last = last;
    p.ovf = ovf;
    return p;
  endfunction

  // All I at v, all Q at -v, identity rotation: peak is |v|
  function automatic point_t flat_point(input logic [15:0] v, input bit last, input bit ovf);
    return mk_point({4{v}}, {4{16'(-v)}}, RotUnity, 32'h0, last, ovf);
  endfunction

  function automatic logic [15:0] rand_sample(input level_e lvl);
    logic [15:0] v;
    case (lvl)
      LvlTiny: v = 16'($urandom_range(0, 200)) - 16'd100;
      LvlNearThreshold: begin
        if ($urandom_range(0, 7) == 0)
          v = 16'($urandom_range(5990, 6210));
        else
          v = 16'($urandom_range(0, 6000));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  function automatic point_t random_point(input level_e lvl, input bit last);
    point_t p;
    int     ch;
    for (ch = 0; ch < NumLanes; ch++) begin
      p.raw_i[ch] = rand_sample(lvl);
      p.raw_q[ch] = rand_sample(lvl);
    end
    if ($urandom_range(0, 3) != 0) begin
      // unit-range pair
      p.cos_v = 32'($urandom_range(32'h8000_0000, 0)) - RotOne;
      p.sin_v = 32'($urandom_range(32'h8000_0000, 0)) - RotOne;
    end else begin
      p.cos_v = $urandom();
      p.sin_v = $urandom();
    end
    p.last = last;
    // overflow flag off the last point is noise the block must ignore
    p.ovf = last ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) == 0);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_rotation_extremes();
    send_point(mk_point({4{16'h7FFF}}, {4{16'h7FFF}}, RotUnity, 32'h0, 0, 0));
    send_point(mk_point({4{16'h8000}}, {4{16'h8000}}, RotUnity, 32'h0, 0, 0));
    // quarter turn
    send_point(mk_point({16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF},
                        {16'h0000, 16'h0001, 16'h7FFF, 16'h8000}, 32'h0, RotOne, 0, 0));
    send_point(mk_point({4{16'h7FFF}}, {4{16'h8000}}, RotMinusOne, RotMinusOne, 0, 0));
    // most negative sine: negation must not overflow
    send_point(mk_point({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                        {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, RotMin, RotMin, 0, 0));
    // out-of-range pair, result wraps
    send_point(mk_point({16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB},
                        {16'h7FFF, 16'h7FFF, 16'hA5A5, 16'h5A5A}, RotUnity, RotUnity, 0, 0));
    // half-LSB ties at scale 1/2
    send_point(mk_point({16'hFFFD, 16'h0003, 16'hFFFF, 16'h0001}, '0, RotOne, 32'h0, 0, 0));
    send_point(mk_point('0, '0, 32'h0, 32'h0, 0, 1));
  endtask

  task automatic test_mean_rounding();
    send_point(mk_point({16'h0, 16'h0, 16'h0, 16'h0001}, {16'h0, 16'h0, 16'h0, 16'h0002},
                        RotUnity, 32'h0, 0, 0));
    // negative sums truncate toward zero
    send_point(mk_point({16'h0, 16'h0, 16'h0, 16'hFFFD}, {16'h0, 16'h0, 16'h0, 16'hFFF9},
                        RotUnity, 32'h0, 0, 0));
    send_point(mk_point({4{16'h8000}}, {4{16'h7FFF}}, RotUnity, 32'h0, 0, 0));
  endtask

  task automatic test_autogain_steps();
    // regs at reset: autogain off, peak still cleared
    send_point(flat_point(16'd10, 1, 1));
    // gain 0 cannot step down
    program_regs(8'h01, 8'h00, 1'b0);
    send_point(flat_point(16'd10, 1, 0));
    // just under threshold steps down
    program_regs(8'h81, 8'h03, 1'b1);
    send_point(flat_point(16'd6099, 1, 0));
    // threshold reached on an earlier point of the sweep
    program_regs(8'h01, 8'hF3, 1'b0);
    send_point(flat_point(16'd6100, 0, 0));
    send_point(flat_point(16'd5, 1, 0));
    // overflow steps up
    program_regs(8'hFF, 8'h03, 1'b0);
    send_point(flat_point(16'd20000, 1, 1));
    program_regs(8'h01, 8'h08, 1'b0);
    send_point(flat_point(16'd20000, 1, 1));
    // gain 7: overflow would leave the range
    program_regs(8'h01, 8'h07, 1'b0);
    send_point(flat_point(16'd20000, 1, 1));
    // gain 7 uses the lower threshold
    send_point(flat_point(16'd94, 1, 0));
    send_point(flat_point(16'd95, 1, 0));
    send_point(flat_point(16'h8000, 1, 0));
    program_regs(8'h01, 8'h06, 1'b0);
    send_point(flat_point(16'd200, 1, 0));
  endtask

  task automatic test_random_sweeps(input int n_items);
    int     sent, len, k;
    bit     paused;
    level_e lvl;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0)
        program_regs({7'($urandom()), 1'($urandom_range(0, 3) != 0)},
                     8'($urandom()), $urandom_range(0, 3) == 0);
      // hold off once mid-run until the pipeline is empty
      if (!paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      len = $urandom_range(1, 10);
      lvl = level_e'($urandom_range(0, 2));
      for (k = 0; k < len; k++) begin
        if (sent >= n_items - 60) traffic_idle = 1'b0;
        send_point(random_point(lvl, k == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_rotation_extremes();
    test_mean_rounding();
    test_autogain_steps();
    test_random_sweeps(330);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ira_pkg.sv
rtl/ira_rotate.sv
rtl/ira_power.sv
rtl/ira_merge.sv
rtl/iq_rotate_average_autogain.sv
tb/iq_rotate_average_autogain_tb.sv
